// File: design/rcg_pkg.sv
// shared types and constants for the roberts cross gradient block
`default_nettype none

package rcg_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W     = 8;
  localparam int GRAD_W    = 9;
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 10;
  localparam int CFG_W     = 12;
  localparam int IWIDTH_W  = 11;
  localparam int WCALC_W   = 13;
  localparam int SQ_W      = 16;
  localparam int REM_W     = 17;
  localparam int ROOT_W    = 9;

  localparam logic [IWIDTH_W-1:0] WIDTH_RESET  = 11'd450;
  localparam logic [ROW_W-1:0]    HEIGHT_RESET = 12'd300;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [1:0] SLOT_MAIN   = 2'd0;
  localparam logic [1:0] SLOT_RIGHT  = 2'd1;
  localparam logic [1:0] SLOT_BELOW  = 2'd2;
  localparam logic [1:0] SLOT_CORNER = 2'd3;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_ROOT, ST_EMIT} ctl_state_t;

  typedef enum logic [1:0] {SQ_IDLE, SQ_SUM, SQ_ITER} sq_state_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_res_t;

endpackage

`default_nettype wire

// File: design/rcg_line_mem.sv
// one-row line buffer, synchronous read-first memory
`default_nettype none

module rcg_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            addr,
  input  wire logic [rcg_pkg::PIX_W-1:0] wdata,
  output logic      [rcg_pkg::PIX_W-1:0] rdata
);
  import rcg_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: design/rcg_sqrt.sv
// iterative floor square root of gx squared plus gy squared
`default_nettype none

module rcg_sqrt (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [rcg_pkg::GRAD_W-1:0] dx,
  input  wire logic signed [rcg_pkg::GRAD_W-1:0] dy,
  output rcg_pkg::root_res_t                    res
);
  import rcg_pkg::*;

  sq_state_t          state;
  sq_state_t          state_next;
  logic               done;
  logic [SQ_W-1:0]    sq_x;
  logic [SQ_W-1:0]    sq_y;
  logic [REM_W-1:0]   rem;
  logic [REM_W:0]     root;
  logic [REM_W-1:0]   bitv;
  logic [3:0]         cnt;
  logic [REM_W:0]     trial;
  logic signed [2*GRAD_W-1:0] prod_x;
  logic signed [2*GRAD_W-1:0] prod_y;

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign trial  = root + {1'b0, bitv};

  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE: begin
        if (start) state_next = SQ_SUM;
      end
      SQ_SUM: begin
        state_next = SQ_ITER;
      end
      SQ_ITER: begin
        if (cnt == 4'd0) state_next = SQ_IDLE;
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == SQ_ITER) && (cnt == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == SQ_IDLE && start) begin
      sq_x <= prod_x[SQ_W-1:0];
      sq_y <= prod_y[SQ_W-1:0];
    end
    if (state == SQ_SUM) begin
      rem  <= {1'b0, sq_x} + {1'b0, sq_y};
      root <= '0;
      bitv <= 17'h10000;
      cnt  <= 4'd8;
    end
    if (state == SQ_ITER) begin
      if ({1'b0, rem} >= trial) begin
        rem  <= rem - trial[REM_W-1:0];
        root <= (root >> 1) + {1'b0, bitv};
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt - 4'd1;
    end
  end

  assign res.done = done;
  assign res.root = root[ROOT_W-1:0];

endmodule

`default_nettype wire

// File: design/roberts_cross_gradient_magnitude.sv
// roberts cross gradient magnitude over a raster pixel stream
// one pixel at a time: after a pixel is taken its square root is computed, then one result
// per cycle while out_stall is low, for up to four results; pixels with no result (row 0, column 0)
// skip the nine-step square-root iteration that the others run; the next pixel is taken the cycle
// after the last result of the previous one is delivered
// synchronous reset clears counters, neighbor pixels and control; the line buffer needs none
`default_nettype none

module roberts_cross_gradient_magnitude #(
  parameter int MAX_WIDTH = rcg_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [rcg_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [rcg_pkg::PIX_W-1:0]           pixel,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [rcg_pkg::GRAD_W-1:0]        grad_x,
  output logic signed [rcg_pkg::GRAD_W-1:0]        grad_y,
  output logic        [rcg_pkg::ROOT_W-1:0]        magnitude,
  output logic        [rcg_pkg::PIX_W-1:0]         shown_x,
  output logic        [rcg_pkg::PIX_W-1:0]         shown_y,
  output logic        [rcg_pkg::PIX_W-1:0]         shown_magnitude,
  output logic        [rcg_pkg::ROW_W-1:0]         out_row,
  output logic        [rcg_pkg::COL_OUT_W-1:0]     out_col,
  output logic                                     frame_last
);
  import rcg_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [WCALC_W-1:0] W_MAX = WCALC_W'(MAX_WIDTH);

  ctl_state_t          state;
  ctl_state_t          state_next;

  logic [IWIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]    image_height;
  logic [WCALC_W-1:0]  w_raw;
  logic [WCALC_W-1:0]  w_eff;
  logic [ROW_W-1:0]    h_eff;

  logic [AW-1:0]       col_count;
  logic [ROW_W-1:0]    row_count;
  logic [PIX_W-1:0]    prev_pixel_now;
  logic [PIX_W-1:0]    prev_pixel_above;

  logic                accept;
  logic                last_col_now;
  logic                last_row_now;
  logic                has_now;

  logic [PIX_W-1:0]    d_reg;
  logic [AW-1:0]       c_reg;
  logic [ROW_W-1:0]    r_reg;
  logic                lc_reg;
  logic                lr_reg;
  logic                has_reg;

  logic [PIX_W-1:0]    line_rdata;
  logic signed [GRAD_W-1:0] p_now;
  logic signed [GRAD_W-1:0] q_now;
  logic signed [GRAD_W-1:0] p_reg;
  logic signed [GRAD_W-1:0] q_reg;

  root_res_t           root_res;
  logic                sqrt_start;

  logic [1:0]          slot;
  logic [1:0]          slot_after;
  logic                more;
  logic                load_out;
  logic                clear_out;
  logic [1:0]          load_slot;

  logic signed [GRAD_W-1:0] gx_sel;
  logic signed [GRAD_W-1:0] gy_sel;
  logic [ROW_W-1:0]    row_sel;
  logic [AW-1:0]       col_sel;
  logic [WCALC_W-1:0]  col_ext;
  logic                last_sel;
  logic [GRAD_W:0]     sx_sum;
  logic [GRAD_W:0]     sy_sum;

  // effective frame size
  assign w_raw = {2'b00, image_width};
  assign w_eff = (w_raw < WCALC_W'(2)) ? WCALC_W'(2) : ((w_raw > W_MAX) ? W_MAX : w_raw);
  assign h_eff = (image_height < ROW_W'(2)) ? ROW_W'(2) : image_height;

  assign in_stall     = (state != ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign last_col_now = WCALC_W'(col_count) >= (w_eff - WCALC_W'(1));
  assign last_row_now = row_count >= (h_eff - ROW_W'(1));
  assign has_now      = (row_count != '0) && (col_count != '0);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IWIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  rcg_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .wr_en (accept),
    .addr  (col_count),
    .wdata (pixel),
    .rdata (line_rdata)
  );

  // frame position and neighbor pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count        <= '0;
      row_count        <= '0;
      prev_pixel_now   <= '0;
      prev_pixel_above <= '0;
    end else begin
      if (accept) begin
        if (last_col_now) begin
          col_count <= '0;
          row_count <= last_row_now ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + AW'(1);
        end
      end
      if (state == ST_READ) begin
        prev_pixel_above <= line_rdata;
        prev_pixel_now   <= d_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_reg   <= pixel;
      c_reg   <= col_count;
      r_reg   <= row_count;
      lc_reg  <= last_col_now;
      lr_reg  <= last_row_now;
      has_reg <= has_now;
    end
    if (state == ST_READ) begin
      p_reg <= p_now;
      q_reg <= q_now;
    end
  end

  assign p_now = $signed({1'b0, prev_pixel_above}) - $signed({1'b0, d_reg});
  assign q_now = $signed({1'b0, line_rdata}) - $signed({1'b0, prev_pixel_now});

  assign sqrt_start = (state == ST_READ) && has_reg;

  rcg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .dx    (p_now),
    .dy    (q_now),
    .res   (root_res)
  );

  // which result follows the current one
  always_comb begin
    slot_after = SLOT_MAIN;
    more       = 1'b0;
    case (slot)
      SLOT_MAIN: begin
        if (lc_reg) begin
          slot_after = SLOT_RIGHT;
          more       = 1'b1;
        end else if (lr_reg) begin
          slot_after = SLOT_BELOW;
          more       = 1'b1;
        end
      end
      SLOT_RIGHT: begin
        if (lr_reg) begin
          slot_after = SLOT_BELOW;
          more       = 1'b1;
        end
      end
      SLOT_BELOW: begin
        if (lc_reg) begin
          slot_after = SLOT_CORNER;
          more       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    clear_out  = 1'b0;
    load_slot  = SLOT_MAIN;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = has_reg ? ST_ROOT : ST_IDLE;
      end
      ST_ROOT: begin
        if (root_res.done) begin
          load_out   = 1'b1;
          load_slot  = SLOT_MAIN;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (more) begin
            load_out  = 1'b1;
            load_slot = slot_after;
          end else begin
            clear_out  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (clear_out) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result fields for the slot being loaded
  always_comb begin
    gx_sel   = p_reg;
    gy_sel   = q_reg;
    row_sel  = r_reg - ROW_W'(1);
    col_sel  = c_reg - AW'(1);
    last_sel = 1'b0;
    case (load_slot)
      SLOT_RIGHT: begin
        gx_sel  = q_reg;
        gy_sel  = p_reg;
        col_sel = c_reg;
      end
      SLOT_BELOW: begin
        gx_sel  = -q_reg;
        gy_sel  = -p_reg;
        row_sel = r_reg;
      end
      SLOT_CORNER: begin
        gx_sel   = -p_reg;
        gy_sel   = -q_reg;
        row_sel  = r_reg;
        col_sel  = c_reg;
        last_sel = 1'b1;
      end
      default: ;
    endcase
  end

  assign col_ext = WCALC_W'(col_sel);
  assign sx_sum  = {gx_sel[GRAD_W-1], gx_sel} + (GRAD_W+1)'(256);
  assign sy_sum  = {gy_sel[GRAD_W-1], gy_sel} + (GRAD_W+1)'(256);

  always_ff @(posedge clk) begin
    if (load_out) begin
      slot            <= load_slot;
      grad_x          <= gx_sel;
      grad_y          <= gy_sel;
      magnitude       <= root_res.root;
      shown_x         <= sx_sum[PIX_W:1];
      shown_y         <= sy_sum[PIX_W:1];
      shown_magnitude <= root_res.root[ROOT_W-1] ? 8'hFF : root_res.root[PIX_W-1:0];
      out_row         <= row_sel;
      out_col         <= col_ext[COL_OUT_W-1:0];
      frame_last      <= last_sel;
    end
  end

endmodule

`default_nettype wire
